### rtl/ttms_pkg.sv
// shared types and constants for the thresholded tanimoto similarity block
// no dependencies; imported by ttms_ratio and the top level

package ttms_pkg;

  // fixed widths of the result fields
  localparam int OUT_CNT_W   = 32;
  localparam int SIM_W       = 17;
  localparam int OUT_TDATA_W = ((2 * OUT_CNT_W + SIM_W + 7) / 8) * 8;

  // status of the ratio unit as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } ratio_status_t;

endpackage

### rtl/thresholded_tanimoto_map_similarity.sv
// a point without the last flag passes through the bit-serial compare chain, which walks all
//   sign-extended sample bits; a last point then also passes the divider and the output load
// a new point is taken only once the block is back in idle; a result waits in the output
//   register while the next points are taken
// reset: asynchronous active low; counters cleared, control, result and configuration registers take their defaults

module thresholded_tanimoto_map_similarity #(
  parameter int COUNT_WIDTH         = 32,
  parameter int SAMPLE_WIDTH        = 32,
  parameter int RATIO_FRACTION_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // slave stream: target_sample, probe_sample from bit 0 up; last_point on tlast
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  input  logic                                    s_axis_tlast,
  // master stream: union_total, intersect_total, similarity from bit 0 up
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [ttms_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [4:0]                              paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import ttms_pkg::*;

  // serial width: room for |sample|, bounds and the tolerance sums without wrap
  localparam int EXT_W = ((SAMPLE_WIDTH > 32) ? SAMPLE_WIDTH : 32) + 2;
  localparam int CNT_W = $clog2(EXT_W);
  localparam int PAD_W = OUT_TDATA_W - 2 * OUT_CNT_W - SIM_W;

  // register map, word addresses
  localparam logic [2:0] REG_COMBINE = 3'd0;
  localparam logic [2:0] REG_KIND    = 3'd1;
  localparam logic [2:0] REG_UMIN    = 3'd2;
  localparam logic [2:0] REG_UMAX    = 3'd3;
  localparam logic [2:0] REG_TOL     = 3'd4;

  // combine modes
  localparam logic [1:0] MODE_EITHER   = 2'd0;
  localparam logic [1:0] MODE_BOTH     = 2'd1;
  localparam logic [1:0] MODE_TGT_ONLY = 2'd2;
  localparam logic [1:0] MODE_PRB_ONLY = 2'd3;

  // map kinds; the unused code behaves as lower bound only
  localparam logic [1:0] KIND_LOWER  = 2'd0;
  localparam logic [1:0] KIND_WINDOW = 2'd1;
  localparam logic [1:0] KIND_MAG    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DIV,
    ST_OUT
  } state_e;

  // 3-input serial adder: {carry[1:0], sum}
  function automatic logic [2:0] ser_add(input logic a, input logic b, input logic c,
                                         input logic [1:0] cin);
    logic [2:0] s;
    s = 3'(a) + 3'(b) + 3'(c) + 3'(cin);
    return s;
  endfunction

  // configuration registers
  logic [1:0]        combine_q;
  logic [1:0]        kind_q;
  logic signed [31:0] umin_q;
  logic signed [31:0] umax_q;
  logic [30:0]       tol_q;

  // control
  state_e           state_q;
  logic [CNT_W-1:0] bit_cnt_q;
  logic             last_q;

  // bit-serial datapath
  logic [EXT_W-1:0] t_sr_q, p_sr_q, min_sr_q, max_sr_q, tol_sr_q;
  logic             t_neg_q, p_neg_q;
  logic [1:0]       c_tlo_q, c_thi_q, c_plo_q, c_phi_q, c_da_q, c_db_q;
  logic             nz_q;

  // counters and the snapshot handed to the divider
  logic [COUNT_WIDTH-1:0] union_q, inter_q;
  logic [COUNT_WIDTH-1:0] res_union_q, res_inter_q;

  // result register
  logic                 m_valid_q;
  logic [OUT_CNT_W-1:0] out_union_q, out_inter_q;
  logic [SIM_W-1:0]     out_sim_q;

  // input fields
  logic [SAMPLE_WIDTH-1:0] tgt_in, prb_in;
  logic                    in_xfer;
  logic                    abs_sel, window_sel;
  logic                    flip_t_in, flip_p_in, flip_t, flip_p;

  // serial adder outputs
  logic [2:0] tlo, thi, plo, phi, da, db;
  logic       last_step;
  logic       qual_t, qual_p, hit, in_tol;
  logic [COUNT_WIDTH-1:0] union_nxt, inter_nxt;
  logic       div_start;
  logic       out_load;

  logic [RATIO_FRACTION_BITS:0]       quo;
  ratio_status_t                      ratio_st;
  logic [COUNT_WIDTH+OUT_CNT_W-1:0]   union_ext, inter_ext;
  logic [RATIO_FRACTION_BITS+SIM_W:0] quo_ext;

  logic cfg_wr;

  assign tgt_in  = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign prb_in  = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  assign abs_sel    = (kind_q == KIND_MAG);
  assign window_sel = (kind_q == KIND_WINDOW) || (kind_q == KIND_MAG);

  // magnitude window on a negative sample works on its negation
  assign flip_t_in = abs_sel && tgt_in[SAMPLE_WIDTH-1];
  assign flip_p_in = abs_sel && prb_in[SAMPLE_WIDTH-1];
  assign flip_t    = abs_sel && t_neg_q;
  assign flip_p    = abs_sel && p_neg_q;

  // lower test: s - min (or -s - min); upper test: max - s (or max + s)
  // tolerance: t - p - tol <= 0 and t - p + tol >= 0
  always_comb begin
    tlo = ser_add(t_sr_q[0] ^ flip_t, ~min_sr_q[0], 1'b0, c_tlo_q);
    thi = ser_add(max_sr_q[0], t_sr_q[0] ^ ~flip_t, 1'b0, c_thi_q);
    plo = ser_add(p_sr_q[0] ^ flip_p, ~min_sr_q[0], 1'b0, c_plo_q);
    phi = ser_add(max_sr_q[0], p_sr_q[0] ^ ~flip_p, 1'b0, c_phi_q);
    da  = ser_add(t_sr_q[0], ~p_sr_q[0], ~tol_sr_q[0], c_da_q);
    db  = ser_add(t_sr_q[0], ~p_sr_q[0], tol_sr_q[0], c_db_q);
  end

  assign last_step = (state_q == ST_SHIFT) && (bit_cnt_q == CNT_W'(EXT_W - 1));

  // on the last serial bit the sum bits are the sign bits
  always_comb begin
    qual_t = !tlo[0] && (!window_sel || !thi[0]);
    qual_p = !plo[0] && (!window_sel || !phi[0]);
    case (combine_q)
      MODE_EITHER:   hit = qual_t || qual_p;
      MODE_BOTH:     hit = qual_t && qual_p;
      MODE_TGT_ONLY: hit = qual_t;
      MODE_PRB_ONLY: hit = qual_p;
      default:       hit = qual_t || qual_p;
    endcase
    in_tol = (da[0] || !nz_q) && !db[0];

    union_nxt = union_q;
    inter_nxt = inter_q;
    if (hit) begin
      if (union_q != '1) begin
        union_nxt = union_q + COUNT_WIDTH'(1);
      end
      if (in_tol && (inter_q != '1)) begin
        inter_nxt = inter_q + COUNT_WIDTH'(1);
      end
    end
  end

  assign div_start = last_step && last_q;
  assign out_load  = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  ttms_ratio #(
    .COUNT_WIDTH        (COUNT_WIDTH),
    .RATIO_FRACTION_BITS(RATIO_FRACTION_BITS)
  ) u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (inter_nxt),
    .den_i   (union_nxt),
    .quo_o   (quo),
    .status_o(ratio_st)
  );

  // counts are cut or padded to the 32-bit result fields
  assign union_ext = {{OUT_CNT_W{1'b0}}, res_union_q};
  assign inter_ext = {{OUT_CNT_W{1'b0}}, res_inter_q};
  assign quo_ext   = {{SIM_W{1'b0}}, quo};

  // sequencer, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      union_q     <= '0;
      inter_q     <= '0;
      m_valid_q   <= 1'b0;
      out_union_q <= '0;
      out_inter_q <= '0;
      out_sim_q   <= '0;
    end else begin
      // result register fills on a load and empties on an output transfer
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q   <= ST_SHIFT;
            bit_cnt_q <= '0;
          end
        end
        ST_SHIFT: begin
          bit_cnt_q <= bit_cnt_q + CNT_W'(1);
          if (last_step) begin
            if (last_q) begin
              union_q <= '0;
              inter_q <= '0;
              state_q <= ST_DIV;
            end else begin
              union_q <= union_nxt;
              inter_q <= inter_nxt;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_DIV: begin
          if (ratio_st.done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_union_q <= union_ext[OUT_CNT_W-1:0];
            out_inter_q <= inter_ext[OUT_CNT_W-1:0];
            out_sim_q   <= quo_ext[SIM_W-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // serial operands: loaded sign-extended on a transfer, shifted one bit a cycle
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      t_sr_q   <= {{(EXT_W-SAMPLE_WIDTH){tgt_in[SAMPLE_WIDTH-1]}}, tgt_in};
      p_sr_q   <= {{(EXT_W-SAMPLE_WIDTH){prb_in[SAMPLE_WIDTH-1]}}, prb_in};
      min_sr_q <= {{(EXT_W-32){umin_q[31]}}, umin_q};
      max_sr_q <= {{(EXT_W-32){umax_q[31]}}, umax_q};
      tol_sr_q <= {{(EXT_W-31){1'b0}}, tol_q};
      t_neg_q  <= tgt_in[SAMPLE_WIDTH-1];
      p_neg_q  <= prb_in[SAMPLE_WIDTH-1];
      last_q   <= s_axis_tlast;
      c_tlo_q  <= flip_t_in ? 2'd2 : 2'd1;
      c_thi_q  <= flip_t_in ? 2'd0 : 2'd1;
      c_plo_q  <= flip_p_in ? 2'd2 : 2'd1;
      c_phi_q  <= flip_p_in ? 2'd0 : 2'd1;
      c_da_q   <= 2'd2;
      c_db_q   <= 2'd1;
      nz_q     <= 1'b0;
    end else if (state_q == ST_SHIFT) begin
      t_sr_q   <= t_sr_q >> 1;
      p_sr_q   <= p_sr_q >> 1;
      min_sr_q <= min_sr_q >> 1;
      max_sr_q <= max_sr_q >> 1;
      tol_sr_q <= tol_sr_q >> 1;
      c_tlo_q  <= tlo[2:1];
      c_thi_q  <= thi[2:1];
      c_plo_q  <= plo[2:1];
      c_phi_q  <= phi[2:1];
      c_da_q   <= da[2:1];
      c_db_q   <= db[2:1];
      nz_q     <= nz_q | da[0];
    end
    if (div_start) begin
      res_union_q <= union_nxt;
      res_inter_q <= inter_nxt;
    end
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      combine_q <= MODE_EITHER;
      kind_q    <= KIND_LOWER;
      umin_q    <= 32'sd16384;
      umax_q    <= 32'sd6553600;
      tol_q     <= 31'd16384;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_COMBINE: combine_q <= pwdata[1:0];
        REG_KIND:    kind_q    <= pwdata[1:0];
        REG_UMIN:    umin_q    <= pwdata;
        REG_UMAX:    umax_q    <= pwdata;
        REG_TOL:     tol_q     <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_COMBINE: prdata = {30'b0, combine_q};
      REG_KIND:    prdata = {30'b0, kind_q};
      REG_UMIN:    prdata = umin_q;
      REG_UMAX:    prdata = umax_q;
      REG_TOL:     prdata = {1'b0, tol_q};
      default:     prdata = '0;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_sim_q, out_inter_q, out_union_q};

`ifndef SYNTHESIS
  // a new point is only taken when the divider is free
  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !ratio_st.busy)
    else $error("point accepted while ratio unit busy");

  // counters restart once the last point of a map is handed off
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (union_q == '0) && (inter_q == '0))
    else $error("counters not cleared after last point");

  // intersection never exceeds union in the snapshot sent to the divider
  a_inter_le_union: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (res_inter_q <= res_union_q))
    else $error("intersection count above union count");
`endif

endmodule

### rtl/ttms_ratio.sv
// restoring divider for the intersection / union ratio, one quotient bit per cycle
// depends on ttms_pkg (ratio_status_t)

module ttms_ratio #(
  parameter int COUNT_WIDTH         = 32,
  parameter int RATIO_FRACTION_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [COUNT_WIDTH-1:0]       num_i,
  input  logic [COUNT_WIDTH-1:0]       den_i,
  output logic [RATIO_FRACTION_BITS:0] quo_o,
  output ttms_pkg::ratio_status_t      status_o
);
  import ttms_pkg::*;

  localparam int STEPS  = RATIO_FRACTION_BITS + 1;
  localparam int STEP_W = $clog2(STEPS + 1);

  logic                         busy_q;
  logic                         done_q;
  logic [STEP_W-1:0]            step_q;
  logic [COUNT_WIDTH:0]         rem_q;
  logic [COUNT_WIDTH-1:0]       den_q;
  logic [RATIO_FRACTION_BITS:0] quo_q;
  logic                         zero_q;

  logic [COUNT_WIDTH:0] cand;
  logic                 ge;

  // integer bit compares the unshifted remainder, later bits shift first
  always_comb begin
    if (step_q == '0) begin
      cand = rem_q;
    end else begin
      cand = {rem_q[COUNT_WIDTH-1:0], 1'b0};
    end
    ge = (cand >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      // one-cycle pulse after the final quotient bit
      done_q <= !start_i && busy_q && (step_q == STEP_W'(STEPS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quo_q  <= '0;
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      rem_q <= ge ? (cand - {1'b0, den_q}) : cand;
      quo_q <= {quo_q[RATIO_FRACTION_BITS-1:0], ge};
    end
  end

  // empty union gives zero
  assign quo_o         = zero_q ? '0 : quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

### sim/tb.sv
// self-checking bench for thresholded_tanimoto_map_similarity: a table of map points, then
// random maps under a series of register settings, each result checked against a hand-written value or a predictor
// needs rtl/ttms_pkg.sv, rtl/ttms_ratio.sv and rtl/thresholded_tanimoto_map_similarity.sv
`timescale 1ns / 100ps

module tb;

  localparam int IN_W         = 64;
  localparam int OUT_W        = ttms_pkg::OUT_TDATA_W;
  localparam int SETTLE_LIMIT = 64;    // one plain point plus the divider, with margin
  localparam int STALL_LIMIT  = 2000;  // cycles without any transfer before giving up
  localparam int RAND_ITEMS   = 450;

  // register map, one word per register
  typedef enum logic [2:0] {
    REG_COMBINE = 3'd0,
    REG_KIND    = 3'd1,
    REG_UMIN    = 3'd2,
    REG_UMAX    = 3'd3,
    REG_TOL     = 3'd4
  } cfg_reg_e;

  // how the two per-sample tests are merged
  typedef enum logic [1:0] {
    MODE_EITHER   = 2'd0,
    MODE_BOTH     = 2'd1,
    MODE_TGT_ONLY = 2'd2,
    MODE_PRB_ONLY = 2'd3
  } mode_e;

  // which qualifying range a sample is tested against
  typedef enum logic [1:0] {
    KIND_LOWER     = 2'd0,
    KIND_WINDOW    = 2'd1,
    KIND_MAGNITUDE = 2'd2,
    KIND_SPARE     = 2'd3
  } kind_e;

  typedef struct packed {
    logic [31:0] uni;
    logic [31:0] isect;
    logic [16:0] sim;
  } map_result_t;

  // one row of the directed table: either a register write or a map point
  typedef struct packed {
    bit          is_cfg;
    cfg_reg_e    reg_sel;
    logic [31:0] wdata;
    logic [31:0] tgt;
    logic [31:0] prb;
    bit          last;
    bit          typed;   // want holds a hand-written result
    map_result_t want;
  } script_row_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;   // target_sample, probe_sample from bit 0 up
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;         // union_total, intersect_total, similarity from bit 0 up
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [4:0]       paddr         = '0;
  logic [31:0]      pwdata        = '0;
  logic [31:0]      prdata;
  logic             pready;

  thresholded_tanimoto_map_similarity dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers and the two counters
  mode_e              cfg_mode;
  kind_e              cfg_kind;
  logic signed [31:0] cfg_umin;
  logic signed [31:0] cfg_umax;
  logic [30:0]        cfg_tol;
  logic [31:0]        union_count;
  logic [31:0]        isect_count;

  map_result_t results_due[$];   // similarity results still owed by the block

  int     mismatches   = 0;
  int     results_seen = 0;
  int     points_sent  = 0;
  int     settings_run = 0;
  int     idle_cycles  = 0;
  int     tx_burst_left = 0;
  bit     tx_steady    = 1'b0;
  bit     rx_steady    = 1'b0;
  int     rx_stall_left = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // range test of one sample; widened so |min| and the window edges stay exact
  function automatic bit sample_qualifies(input logic [31:0] s);
    longint sv;
    longint mag;
    longint lo;
    longint hi;
    sv  = longint'($signed(s));
    mag = (sv < 0) ? -sv : sv;
    lo  = longint'(cfg_umin);
    hi  = longint'(cfg_umax);
    case (cfg_kind)
      KIND_WINDOW:    return (sv >= lo) && (sv <= hi);
      KIND_MAGNITUDE: return (mag >= lo) && (mag <= hi);
      default:        return sv >= lo;   // the spare kind falls back to the lower bound
    endcase
  endfunction

  // count one accepted point; on the last point of a map form the result and clear
  task automatic tally_point(input logic [31:0] tgt, input logic [31:0] prb, input bit last,
                             output map_result_t res, output bit has_res);
    bit     qt;
    bit     qp;
    bit     hit;
    longint gap;
    logic [63:0] num;
    qt = sample_qualifies(tgt);
    qp = sample_qualifies(prb);
    case (cfg_mode)
      MODE_BOTH:     hit = qt && qp;
      MODE_TGT_ONLY: hit = qt;
      MODE_PRB_ONLY: hit = qp;
      default:       hit = qt || qp;
    endcase
    if (hit) begin
      if (union_count != '1) union_count = union_count + 1;
      gap = longint'($signed(tgt)) - longint'($signed(prb));
      if (gap < 0) gap = -gap;
      if (gap <= longint'({1'b0, cfg_tol}) && isect_count != '1) isect_count = isect_count + 1;
    end
    has_res = last;
    res     = '0;
    if (last) begin
      res.uni   = union_count;
      res.isect = isect_count;
      num       = {32'd0, isect_count} << 16;
      res.sim   = (union_count == 0) ? 17'd0 : 17'(num / {32'd0, union_count});
      union_count = '0;
      isect_count = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // bus drivers
  // ---------------------------------------------------------------------------

  // setup then access phase; psel stays up so writes can follow back to back
  task automatic cfg_write(input cfg_reg_e sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'({sel, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      REG_COMBINE: cfg_mode = mode_e'(value[1:0]);
      REG_KIND:    cfg_kind = kind_e'(value[1:0]);
      REG_UMIN:    cfg_umin = value;
      REG_UMAX:    cfg_umax = value;
      default:     cfg_tol  = value[30:0];
    endcase
  endtask

  task automatic cfg_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one point transfer; unless tx_steady is set, bursts of random length separated by random gaps
  task automatic send_point(input logic [31:0] tgt, input logic [31:0] prb, input bit last);
    int gap;
    if (!tx_steady) begin
      if (tx_burst_left == 0) begin
        gap = $urandom_range(0, 40);
        tx_burst_left = $urandom_range(1, 16);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      tx_burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {prb, tgt};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    points_sent++;
  endtask

  // stop sending, let every owed result arrive, then cover a point still in flight
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_LIMIT) @(posedge clk_i);
  endtask

  task automatic send_and_predict(input logic [31:0] tgt, input logic [31:0] prb,
                                  input bit last);
    map_result_t res;
    bit          has_res;
    send_point(tgt, prb, last);
    tally_point(tgt, prb, last, res, has_res);
    if (has_res) results_due.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // receiver and result checking
  // ---------------------------------------------------------------------------

  // stalls of random length, switched off for whole phases now and then
  always @(posedge clk_i) begin
    if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 5) == 0) begin
      rx_stall_left <= $urandom_range(0, 30);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    map_result_t want;
    map_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.uni   = m_axis_tdata[31:0];
      got.isect = m_axis_tdata[63:32];
      got.sim   = m_axis_tdata[80:64];
      if (results_due.size() == 0) begin
        $display("%0t: result with none owed: union %0d intersect %0d similarity %0d",
                 $time, got.uni, got.isect, got.sim);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        results_seen++;
        if (got.uni !== want.uni) begin
          $display("%0t: union_total expected %0d, got %0d", $time, want.uni, got.uni);
          mismatches++;
        end
        if (got.isect !== want.isect) begin
          $display("%0t: intersect_total expected %0d, got %0d", $time, want.isect, got.isect);
          mismatches++;
        end
        if (got.sim !== want.sim) begin
          $display("%0t: similarity expected %0d, got %0d", $time, want.sim, got.sim);
          mismatches++;
        end
      end
    end
  end

  // watchdog: any transfer on either stream restarts the count
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results owed",
               $time, STALL_LIMIT, results_due.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic script_row_t cfg_row(input cfg_reg_e sel, input logic [31:0] value);
    script_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_sel = sel;
    r.wdata   = value;
    return r;
  endfunction

  function automatic script_row_t pt_row(input logic [31:0] tgt, input logic [31:0] prb,
                                         input bit last);
    script_row_t r;
    r      = '0;
    r.tgt  = tgt;
    r.prb  = prb;
    r.last = last;
    return r;
  endfunction

  // last point of a map whose result is plain to see
  function automatic script_row_t end_row(input logic [31:0] tgt, input logic [31:0] prb,
                                          input logic [31:0] uni, input logic [31:0] isect,
                                          input logic [16:0] sim);
    script_row_t r;
    r            = pt_row(tgt, prb, 1'b1);
    r.typed      = 1'b1;
    r.want.uni   = uni;
    r.want.isect = isect;
    r.want.sim   = sim;
    return r;
  endfunction

  // random sample, mostly close to the edges of the current window or to zero
  function automatic logic [31:0] pick_sample();
    logic [31:0] off;
    off = 32'($urandom_range(0, 8)) - 32'd4;
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return cfg_umin + off;
      2:       return cfg_umax + off;
      3:       return -cfg_umin + off;
      4:       return -cfg_umax + off;
      default: return 32'($urandom_range(0, 32'h60000)) - 32'h30000;
    endcase
  endfunction

  // probe either independent or placed right at the tolerance edge of the target
  function automatic logic [31:0] pick_probe(input logic [31:0] tgt);
    logic [31:0] delta;
    if ($urandom_range(0, 4) < 2) begin
      delta = {1'b0, cfg_tol} + 32'($urandom_range(0, 2)) - 32'd1;
      return $urandom_range(0, 1) ? tgt + delta : tgt - delta;
    end
    return pick_sample();
  endfunction

  // register setting for one random phase; the first two pin the field extremes
  task automatic program_phase(input int phase);
    logic [31:0] mode_v;
    logic [31:0] kind_v;
    logic [31:0] umin_v;
    logic [31:0] umax_v;
    logic [31:0] tol_v;
    if (phase == 0) begin
      // everything qualifies on the lower bound, exact match only
      mode_v = 32'(MODE_EITHER);
      kind_v = 32'(KIND_LOWER);
      umin_v = 32'h8000_0000;
      umax_v = 32'h8000_0000;
      tol_v  = 32'd0;
    end else if (phase == 1) begin
      // full signed window and the widest tolerance
      mode_v = 32'(MODE_BOTH);
      kind_v = 32'(KIND_WINDOW);
      umin_v = 32'h8000_0000;
      umax_v = 32'h7fff_ffff;
      tol_v  = 32'h7fff_ffff;
    end else begin
      mode_v = $urandom_range(0, 3);
      kind_v = $urandom_range(0, 3);
      case ($urandom_range(0, 7))
        0:       umin_v = 32'h8000_0000;
        1:       umin_v = 32'h7fff_ffff;
        2:       umin_v = $urandom;
        default: umin_v = 32'($urandom_range(0, 32'h80000)) - 32'h40000;
      endcase
      case ($urandom_range(0, 7))
        0:       umax_v = 32'h8000_0000;
        1:       umax_v = 32'h7fff_ffff;
        2:       umax_v = umin_v - 32'($urandom_range(1, 32'h10000));   // inverted window
        default: umax_v = umin_v + 32'($urandom_range(0, 32'h400000));
      endcase
      case ($urandom_range(0, 5))
        0:       tol_v = 32'd0;
        1:       tol_v = 32'h7fff_ffff;
        default: tol_v = $urandom_range(0, 32'h20000);
      endcase
    end
    cfg_write(REG_COMBINE, mode_v);
    cfg_write(REG_KIND, kind_v);
    cfg_write(REG_UMIN, umin_v);
    cfg_write(REG_UMAX, umax_v);
    cfg_write(REG_TOL, tol_v);
    cfg_release();
    settings_run++;
  endtask

  initial begin
    script_row_t script[$];
    map_result_t res;
    bit          has_res;
    bit          cfg_open;
    int          phase;
    int          rand_points;
    int          last_every;
    logic [31:0] tgt;

    // predictor starts from the register defaults
    cfg_mode    = MODE_EITHER;
    cfg_kind    = KIND_LOWER;
    cfg_umin    = 32'd16384;
    cfg_umax    = 32'd6553600;
    cfg_tol     = 31'd16384;
    union_count = '0;
    isect_count = '0;

    // empty union under the defaults: zero below the 0.25 bound on both sides
    script.push_back(end_row(32'h0000_0000, 32'h0000_0000, 0, 0, 17'd0));
    // sample extremes: target qualifies, the 33-bit difference is far over tolerance
    script.push_back(end_row(32'h7fff_ffff, 32'h8000_0000, 1, 0, 17'd0));
    // lower bound and tolerance both inclusive, then a perfect match
    script.push_back(pt_row(32'h0000_4000, 32'h0000_0000, 1'b0));
    script.push_back(end_row(32'h0001_0000, 32'h0001_0000, 2, 2, 17'h10000));
    // one miss in two gives one half
    script.push_back(pt_row(32'h0001_0000, 32'h0003_0000, 1'b0));
    script.push_back(end_row(32'h0001_0000, 32'h0001_0000, 2, 1, 17'h08000));
    // both must qualify, widest tolerance
    script.push_back(cfg_row(REG_TOL, 32'h7fff_ffff));
    script.push_back(cfg_row(REG_COMBINE, 32'(MODE_BOTH)));
    script.push_back(pt_row(32'h7fff_ffff, 32'h0000_4000, 1'b0));
    script.push_back(end_row(32'h7fff_ffff, 32'h0000_0000, 1, 1, 17'h10000));
    // target only, full signed window, exact match only
    script.push_back(cfg_row(REG_COMBINE, 32'(MODE_TGT_ONLY)));
    script.push_back(cfg_row(REG_KIND, 32'(KIND_WINDOW)));
    script.push_back(cfg_row(REG_UMIN, 32'h8000_0000));
    script.push_back(cfg_row(REG_UMAX, 32'h7fff_ffff));
    script.push_back(cfg_row(REG_TOL, 32'd0));
    script.push_back(pt_row(32'h8000_0000, 32'h7fff_ffff, 1'b0));
    script.push_back(pt_row(32'h0001_2345, 32'h0001_2345, 1'b0));
    script.push_back(end_row(32'h7fff_ffff, 32'h8000_0000, 3, 1, 17'd21845));
    // probe only, magnitude window 1.0 to 2.0, the most negative probe stays out
    script.push_back(cfg_row(REG_COMBINE, 32'(MODE_PRB_ONLY)));
    script.push_back(cfg_row(REG_KIND, 32'(KIND_MAGNITUDE)));
    script.push_back(cfg_row(REG_UMIN, 32'h0001_0000));
    script.push_back(cfg_row(REG_UMAX, 32'h0002_0000));
    script.push_back(cfg_row(REG_TOL, 32'h0000_8000));
    script.push_back(pt_row(32'h0000_0000, 32'hfffe_0000, 1'b0));
    script.push_back(pt_row(32'h0000_0000, 32'h8000_0000, 1'b0));
    script.push_back(pt_row(32'h0001_8000, 32'h0001_0000, 1'b0));
    script.push_back(end_row(32'h0000_0000, 32'hffff_8000, 2, 1, 17'h08000));
    // the spare kind tests the lower bound alone
    script.push_back(cfg_row(REG_COMBINE, 32'(MODE_EITHER)));
    script.push_back(cfg_row(REG_KIND, 32'(KIND_SPARE)));
    script.push_back(pt_row(32'h0001_0000, 32'h0000_0000, 1'b0));
    script.push_back(end_row(32'hffff_0000, 32'h0001_0000, 2, 0, 17'd0));
    // inverted window lets nothing through, signed or magnitude
    script.push_back(cfg_row(REG_KIND, 32'(KIND_WINDOW)));
    script.push_back(cfg_row(REG_UMIN, 32'h0002_0000));
    script.push_back(cfg_row(REG_UMAX, 32'h0001_0000));
    script.push_back(end_row(32'h0001_8000, 32'h0001_8000, 0, 0, 17'd0));
    script.push_back(cfg_row(REG_KIND, 32'(KIND_MAGNITUDE)));
    script.push_back(end_row(32'hfffe_8000, 32'h0001_8000, 0, 0, 17'd0));
    // lowest bound: every sample counts, top of the range near-matched
    script.push_back(cfg_row(REG_KIND, 32'(KIND_LOWER)));
    script.push_back(cfg_row(REG_UMIN, 32'h8000_0000));
    script.push_back(pt_row(32'h7fff_ffff, 32'h7fff_f000, 1'b0));
    script.push_back(pt_row(32'h8000_0000, 32'h8000_0000, 1'b1));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, register writes only once the block has gone quiet
    cfg_open = 1'b0;
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        if (!cfg_open) begin
          quiesce();
          cfg_open = 1'b1;
        end
        cfg_write(script[i].reg_sel, script[i].wdata);
      end else begin
        if (cfg_open) begin
          cfg_release();
          settings_run++;
          cfg_open = 1'b0;
        end
        send_point(script[i].tgt, script[i].prb, script[i].last);
        tally_point(script[i].tgt, script[i].prb, script[i].last, res, has_res);
        if (has_res) results_due.push_back(script[i].typed ? script[i].want : res);
      end
    end

    // random maps: each phase takes a new register setting and its own idling style
    rand_points = 0;
    phase = 0;
    while (rand_points < RAND_ITEMS) begin
      quiesce();
      program_phase(phase);
      tx_steady  = ($urandom_range(0, 3) == 0);
      rx_steady <= ($urandom_range(0, 3) == 0);
      last_every = $urandom_range(1, 14);
      repeat (50) begin
        tgt = pick_sample();
        send_and_predict(tgt, pick_probe(tgt), $urandom_range(1, last_every) == 1);
        rand_points++;
      end
      phase++;
    end
    // close the map left open by the random part
    send_and_predict(pick_sample(), pick_sample(), 1'b1);

    quiesce();
    $display("covered %0d map points under %0d register settings, %0d similarity results checked",
             points_sent, settings_run, results_seen);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, results_due.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ttms_pkg.sv
rtl/ttms_ratio.sv
rtl/thresholded_tanimoto_map_similarity.sv
sim/tb.sv
